[sv/bze_pkg.sv]
// Shared constants and types for the cubic Bezier evaluator.
// No dependencies; every other file imports it.
package bze_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int PROG_FRAC_DEF  = 16;
    localparam int DIR_W          = 16;
    localparam int DIR_ONE        = 16384;
    localparam int NORM_W         = 30;            // normalized magnitude bits
    localparam int SQ_W           = 2 * NORM_W + 1; // sum of squares
    localparam int ROOT_W         = 31;            // floor sqrt of SQ_W bits
    localparam int RW             = 62;            // sqrt working width
    localparam int QUO_W          = 16;
    localparam int REM_W          = NORM_W + 18;   // divider remainder
    localparam int CFG_IDX_W      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X,
        REG_START_Y,
        REG_END_X,
        REG_END_Y,
        REG_H1_X,
        REG_H1_Y,
        REG_H2_X,
        REG_H2_Y
    } cfg_idx_t;

    typedef struct packed {
        logic oor;
        logic zero;
        logic neg_x;
        logic neg_y;
    } flags_t;

endpackage

[sv/bze_interp.sv]
// de Casteljau subdivision: three registered levels of interpolation.
// Depends on bze_pkg.
module bze_interp #(
    parameter int COORD_BITS         = bze_pkg::COORD_BITS_DEF,
    parameter int PROGRESS_FRAC_BITS = bze_pkg::PROG_FRAC_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_vld,
    input  logic [PROGRESS_FRAC_BITS+1:0]         progress,
    input  logic [1:0][COORD_BITS-1:0]            p0,
    input  logic [1:0][COORD_BITS-1:0]            p1,
    input  logic [1:0][COORD_BITS-1:0]            p2,
    input  logic [1:0][COORD_BITS-1:0]            p3,
    output logic                                  out_vld,
    output logic                                  oor,
    output logic [1:0][COORD_BITS-1:0]            pos,
    output logic [1:0][COORD_BITS:0]              d
);
    import bze_pkg::*;

    localparam int C = COORD_BITS;
    localparam int F = PROGRESS_FRAC_BITS;
    localparam int P = C + F + 3;

    function automatic logic [C-1:0] lerp(input logic [C-1:0] a, input logic [C-1:0] b,
                                          input logic [F:0] t);
        logic signed [C:0]   dd;
        logic signed [P-1:0] pr;
        logic signed [P-1:0] rs;
        dd = $signed({b[C-1], b}) - $signed({a[C-1], a});
        pr = P'(dd) * $signed({{(P-F-1){1'b0}}, t});
        rs = (pr + (P'(1) <<< (F - 1))) >>> F;
        return a + rs[C-1:0];
    endfunction

    logic              oor_in;
    logic [F:0]        t1_reg, t2_reg;
    logic              oor1_reg, oor2_reg, oor3_reg;
    logic              vld1_reg, vld2_reg, vld3_reg;
    logic [1:0][C-1:0] a_reg, b_reg, c_reg, q0_reg, q1_reg, pos_reg;
    logic [1:0][C:0]   d_reg;

    assign oor_in = progress[F+1] | (progress[F] & (|progress[F-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg   <= progress[F:0];
            oor1_reg <= oor_in;
            t2_reg   <= t1_reg;
            oor2_reg <= oor1_reg;
            oor3_reg <= oor2_reg;
            for (int k = 0; k < 2; k++)
            begin
                a_reg[k]   <= lerp(p0[k], p1[k], progress[F:0]);
                b_reg[k]   <= lerp(p1[k], p2[k], progress[F:0]);
                c_reg[k]   <= lerp(p2[k], p3[k], progress[F:0]);
                q0_reg[k]  <= lerp(a_reg[k], b_reg[k], t1_reg);
                q1_reg[k]  <= lerp(b_reg[k], c_reg[k], t1_reg);
                pos_reg[k] <= lerp(q0_reg[k], q1_reg[k], t2_reg);
                d_reg[k]   <= $signed({q1_reg[k][C-1], q1_reg[k]})
                            - $signed({q0_reg[k][C-1], q0_reg[k]});
            end
        end
    end

    assign out_vld = vld3_reg;
    assign oor     = oor3_reg;
    assign pos     = pos_reg;
    assign d       = d_reg;

endmodule

[sv/bze_norm.sv]
// Tangent normalization front end: magnitudes, power-of-two scaling, sum of squares.
// Depends on bze_pkg.
module bze_norm #(
    parameter int COORD_BITS = bze_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic                          oor,
    input  logic [1:0][COORD_BITS-1:0]    pos,
    input  logic [1:0][COORD_BITS:0]      d,
    output logic                          out_vld,
    output bze_pkg::flags_t               flags,
    output logic [1:0][COORD_BITS-1:0]    pos_out,
    output logic [bze_pkg::NORM_W-1:0]    mag_x,
    output logic [bze_pkg::NORM_W-1:0]    mag_y,
    output logic [bze_pkg::SQ_W-1:0]      sum
);
    import bze_pkg::*;

    localparam int A  = COORD_BITS + 1;
    localparam int MW = $clog2(A + 1);
    localparam int EW = A + NORM_W;

    logic [3:0]                vld_reg;
    flags_t                    fl_reg [4];
    logic [1:0][COORD_BITS-1:0] pos_reg [4];
    logic [1:0][A-1:0]         abs_reg;
    logic [1:0][A-1:0]         abs_next;
    logic [NORM_W-1:0]         nx_reg [3], ny_reg [3];
    logic [2*NORM_W-1:0]       sqx_reg, sqy_reg;
    logic [SQ_W-1:0]           sum_reg;
    logic [A-1:0]              ored;
    logic [MW-1:0]             msb;
    logic [MW-1:0]             shamt;
    logic [EW-1:0]             ext_x, ext_y;
    flags_t                    fl_next;

    always_comb
    begin
        for (int k = 0; k < 2; k++)
            abs_next[k] = d[k][A-1] ? A'(-$signed(d[k])) : d[k];
        fl_next.oor   = oor;
        fl_next.zero  = ~|(abs_next[0] | abs_next[1]);
        fl_next.neg_x = d[0][A-1];
        fl_next.neg_y = d[1][A-1];
    end

    // leading one of the larger magnitude, then scale into [2^29, 2^30)
    always_comb
    begin
        ored = abs_reg[0] | abs_reg[1];
        msb  = '0;
        for (int i = 0; i < A; i++)
            if (ored[i])
                msb = MW'(i);
        shamt = msb + MW'(1);
        ext_x = {abs_reg[0], {NORM_W{1'b0}}} >> shamt;
        ext_y = {abs_reg[1], {NORM_W{1'b0}}} >> shamt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs_reg    <= abs_next;
            fl_reg[0]  <= fl_next;
            pos_reg[0] <= pos;
            for (int s = 1; s < 4; s++)
            begin
                fl_reg[s]  <= fl_reg[s-1];
                pos_reg[s] <= pos_reg[s-1];
            end
            nx_reg[0] <= ext_x[NORM_W-1:0];
            ny_reg[0] <= ext_y[NORM_W-1:0];
            for (int s = 1; s < 3; s++)
            begin
                nx_reg[s] <= nx_reg[s-1];
                ny_reg[s] <= ny_reg[s-1];
            end
            sqx_reg <= nx_reg[0] * nx_reg[0];
            sqy_reg <= ny_reg[0] * ny_reg[0];
            sum_reg <= SQ_W'(sqx_reg) + SQ_W'(sqy_reg);
        end
    end

    assign out_vld = vld_reg[3];
    assign flags   = fl_reg[3];
    assign pos_out = pos_reg[3];
    assign mag_x   = nx_reg[2];
    assign mag_y   = ny_reg[2];
    assign sum     = sum_reg;

endmodule

[sv/bze_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on bze_pkg.
module bze_sqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [bze_pkg::SQ_W-1:0]      sum,
    input  logic [SIDE_W-1:0]             side,
    output logic                          out_vld,
    output logic [bze_pkg::ROOT_W-1:0]    root,
    output logic [SIDE_W-1:0]             side_out
);
    import bze_pkg::*;

    logic [SQ_W-1:0]   s_reg    [ROOT_W];
    logic [RW-1:0]     r_reg    [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];
    logic              vld_reg  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_step
        localparam int SH = 2 * (ROOT_W - 1 - i);
        logic [SQ_W-1:0]   s_i, s_next;
        logic [RW-1:0]     r_i, r_next, trial;
        logic [SIDE_W-1:0] side_i;
        logic              vld_i;

        if (i == 0)
        begin : g_first
            assign s_i    = sum;
            assign r_i    = '0;
            assign side_i = side;
            assign vld_i  = in_vld;
        end
        else
        begin : g_rest
            assign s_i    = s_reg[i-1];
            assign r_i    = r_reg[i-1];
            assign side_i = side_reg[i-1];
            assign vld_i  = vld_reg[i-1];
        end

        always_comb
        begin
            trial = r_i + (RW'(1) << SH);
            if (RW'(s_i) >= trial)
            begin
                s_next = s_i - trial[SQ_W-1:0];
                r_next = (r_i >> 1) + (RW'(1) << SH);
            end
            else
            begin
                s_next = s_i;
                r_next = r_i >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s_reg[i]    <= s_next;
                r_reg[i]    <= r_next;
                side_reg[i] <= side_i;
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign root     = r_reg[ROOT_W-1][ROOT_W-1:0];
    assign side_out = side_reg[ROOT_W-1];

endmodule

[sv/bze_div.sv]
// Pipelined restoring divider for both tangent components: round(mag * 16384 / root).
// Depends on bze_pkg.
module bze_div #(
    parameter int SIDE_W = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [bze_pkg::NORM_W-1:0]    mag_x,
    input  logic [bze_pkg::NORM_W-1:0]    mag_y,
    input  logic [bze_pkg::ROOT_W-1:0]    root,
    input  logic [SIDE_W-1:0]             side,
    output logic                          out_vld,
    output logic [bze_pkg::QUO_W-1:0]     quo_x,
    output logic [bze_pkg::QUO_W-1:0]     quo_y,
    output logic [SIDE_W-1:0]             side_out
);
    import bze_pkg::*;

    localparam int DV_W = ROOT_W + 1;
    localparam int ONE_SH = $clog2(DIR_ONE) + 1;   // mag * 2 * DIR_ONE

    logic [1:0][REM_W-1:0] rem_reg  [QUO_W];
    logic [1:0][QUO_W-1:0] q_reg    [QUO_W];
    logic [DV_W-1:0]       dv_reg   [QUO_W];
    logic [SIDE_W-1:0]     side_reg [QUO_W];
    logic                  vld_reg  [QUO_W];

    for (genvar i = 0; i < QUO_W; i++)
    begin : g_step
        localparam int B = QUO_W - 1 - i;
        logic [1:0][REM_W-1:0] rem_i, rem_next;
        logic [1:0][QUO_W-1:0] q_i, q_next;
        logic [DV_W-1:0]       dv_i;
        logic [REM_W-1:0]      dsh;
        logic [SIDE_W-1:0]     side_i;
        logic                  vld_i;

        if (i == 0)
        begin : g_first
            assign rem_i[0] = (REM_W'(mag_x) << ONE_SH) + REM_W'(root);
            assign rem_i[1] = (REM_W'(mag_y) << ONE_SH) + REM_W'(root);
            assign q_i      = '0;
            assign dv_i     = {root, 1'b0};
            assign side_i   = side;
            assign vld_i    = in_vld;
        end
        else
        begin : g_rest
            assign rem_i  = rem_reg[i-1];
            assign q_i    = q_reg[i-1];
            assign dv_i   = dv_reg[i-1];
            assign side_i = side_reg[i-1];
            assign vld_i  = vld_reg[i-1];
        end

        always_comb
        begin
            dsh = REM_W'(dv_i) << B;
            for (int k = 0; k < 2; k++)
            begin
                q_next[k] = q_i[k];
                if (rem_i[k] >= dsh)
                begin
                    rem_next[k]  = rem_i[k] - dsh;
                    q_next[k][B] = 1'b1;
                end
                else
                    rem_next[k] = rem_i[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i] <= 1'b0;
            else if (en)
                vld_reg[i] <= vld_i;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                q_reg[i]    <= q_next;
                dv_reg[i]   <= dv_i;
                side_reg[i] <= side_i;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign quo_x    = q_reg[QUO_W-1][0];
    assign quo_y    = q_reg[QUO_W-1][1];
    assign side_out = side_reg[QUO_W-1];

endmodule

[sv/cubic_bezier_evaluator.sv]
// Cubic Bezier evaluator top level: control point registers, pipeline, output register.
// Depends on bze_pkg, bze_interp, bze_norm, bze_sqrt, bze_div.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   cfg     | cfg_valid cfg_ready cfg_index cfg_data    | in
//   in      | in_valid in_ready progress                | in
//   out     | out_valid out_ready pos_x pos_y dir_x     | out
//           | dir_y out_of_range                        |
//
// One progress value per cycle when not stalled. Pipeline: 3 interpolation levels,
// 4 normalize, 31 square-root (one root bit each) and 16 divider stages, output register.
// Reset clears all valid bits and the control points to zero; no clearing pass.
// The whole pipeline advances whenever the output register is empty or being taken,
// so a stall at out_ready freezes every stage and in_ready together.
module cubic_bezier_evaluator #(
    parameter int COORD_BITS         = bze_pkg::COORD_BITS_DEF,
    parameter int PROGRESS_FRAC_BITS = bze_pkg::PROG_FRAC_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bze_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [COORD_BITS-1:0]            cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [PROGRESS_FRAC_BITS+1:0]    progress,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [COORD_BITS-1:0]            pos_x,
    output logic [COORD_BITS-1:0]            pos_y,
    output logic [bze_pkg::DIR_W-1:0]        dir_x,
    output logic [bze_pkg::DIR_W-1:0]        dir_y,
    output logic                             out_of_range
);
    import bze_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int FL_W   = $bits(flags_t);
    localparam int SIDE2  = FL_W + 2 * C;
    localparam int SIDE1  = SIDE2 + 2 * NORM_W;

    logic [C-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [C-1:0] h1_x_reg, h1_y_reg, h2_x_reg, h2_y_reg;

    logic              en;
    logic              i_vld, n_vld, s_vld, d_vld;
    logic              i_oor;
    logic [1:0][C-1:0] i_pos, n_pos;
    logic [1:0][C:0]   i_d;
    flags_t            n_flags, d_flags;
    logic [NORM_W-1:0] n_mx, n_my;
    logic [SQ_W-1:0]   n_sum;
    logic [ROOT_W-1:0] s_root;
    logic [SIDE1-1:0]  s_side;
    logic [SIDE2-1:0]  d_side;
    logic [QUO_W-1:0]  d_qx, d_qy;
    logic [C-1:0]      d_px, d_py;

    logic              out_valid_reg;
    logic [C-1:0]      pos_x_reg, pos_y_reg, pos_x_next, pos_y_next;
    logic [DIR_W-1:0]  dir_x_reg, dir_y_reg, dir_x_next, dir_y_next;
    logic              oor_reg;

    assign cfg_ready = 1'b1;
    assign en        = ~out_valid_reg | out_ready;
    assign in_ready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
            h1_x_reg    <= '0;
            h1_y_reg    <= '0;
            h2_x_reg    <= '0;
            h2_y_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_START_X: start_x_reg <= cfg_data;
                REG_START_Y: start_y_reg <= cfg_data;
                REG_END_X:   end_x_reg   <= cfg_data;
                REG_END_Y:   end_y_reg   <= cfg_data;
                REG_H1_X:    h1_x_reg    <= cfg_data;
                REG_H1_Y:    h1_y_reg    <= cfg_data;
                REG_H2_X:    h2_x_reg    <= cfg_data;
                REG_H2_Y:    h2_y_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    bze_interp #(
        .COORD_BITS(COORD_BITS),
        .PROGRESS_FRAC_BITS(PROGRESS_FRAC_BITS)
    ) u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_valid),
        .progress (progress),
        .p0       ({start_y_reg, start_x_reg}),
        .p1       ({h1_y_reg, h1_x_reg}),
        .p2       ({h2_y_reg, h2_x_reg}),
        .p3       ({end_y_reg, end_x_reg}),
        .out_vld  (i_vld),
        .oor      (i_oor),
        .pos      (i_pos),
        .d        (i_d)
    );

    bze_norm #(
        .COORD_BITS(COORD_BITS)
    ) u_norm (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (i_vld),
        .oor     (i_oor),
        .pos     (i_pos),
        .d       (i_d),
        .out_vld (n_vld),
        .flags   (n_flags),
        .pos_out (n_pos),
        .mag_x   (n_mx),
        .mag_y   (n_my),
        .sum     (n_sum)
    );

    bze_sqrt #(
        .SIDE_W(SIDE1)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (n_vld),
        .sum      (n_sum),
        .side     ({n_flags, n_pos[1], n_pos[0], n_my, n_mx}),
        .out_vld  (s_vld),
        .root     (s_root),
        .side_out (s_side)
    );

    bze_div #(
        .SIDE_W(SIDE2)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s_vld),
        .mag_x    (s_side[NORM_W-1:0]),
        .mag_y    (s_side[2*NORM_W-1:NORM_W]),
        .root     (s_root),
        .side     (s_side[SIDE1-1:2*NORM_W]),
        .out_vld  (d_vld),
        .quo_x    (d_qx),
        .quo_y    (d_qy),
        .side_out (d_side)
    );

    assign d_px    = d_side[C-1:0];
    assign d_py    = d_side[2*C-1:C];
    assign d_flags = flags_t'(d_side[SIDE2-1:2*C]);

    always_comb
    begin
        pos_x_next = d_px;
        pos_y_next = d_py;
        dir_x_next = d_flags.neg_x ? DIR_W'(-d_qx) : DIR_W'(d_qx);
        dir_y_next = d_flags.neg_y ? DIR_W'(-d_qy) : DIR_W'(d_qy);
        if (d_flags.oor)
        begin
            pos_x_next = '0;
            pos_y_next = '0;
            dir_x_next = '0;
            dir_y_next = '0;
        end
        else if (d_flags.zero)
        begin
            dir_x_next = '0;
            dir_y_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            dir_x_reg <= dir_x_next;
            dir_y_reg <= dir_y_next;
            oor_reg   <= d_flags.oor;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign dir_x        = dir_x_reg;
    assign dir_y        = dir_y_reg;
    assign out_of_range = oor_reg;

endmodule

[sv/bze_checker.sv]
// Port-level checks for the cubic Bezier evaluator, bound to the top level.
// Depends on bze_pkg and cubic_bezier_evaluator.
module bze_checker #(
    parameter int COORD_BITS         = bze_pkg::COORD_BITS_DEF,
    parameter int PROGRESS_FRAC_BITS = bze_pkg::PROG_FRAC_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [PROGRESS_FRAC_BITS+1:0]    progress,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [COORD_BITS-1:0]            pos_x,
    input logic [COORD_BITS-1:0]            pos_y,
    input logic [bze_pkg::DIR_W-1:0]        dir_x,
    input logic [bze_pkg::DIR_W-1:0]        dir_y,
    input logic                             out_of_range
);
    import bze_pkg::*;

    localparam logic signed [DIR_W-1:0] DMAX = DIR_W'(DIR_ONE);
    localparam logic signed [DIR_W-1:0] DMIN = -DIR_W'(DIR_ONE);

    // out-of-range transactions carry all-zero vectors
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> pos_x == '0 && pos_y == '0 && dir_x == '0 && dir_y == '0)
        else $error("out_of_range result with nonzero vector");

    // tangent stays within unit magnitude per component
    a_dir_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(dir_x) <= DMAX && $signed(dir_x) >= DMIN
                   && $signed(dir_y) <= DMAX && $signed(dir_y) >= DMIN)
        else $error("tangent component beyond unit range");

    // empty output register never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with empty output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(dir_x)
                                 && $stable(out_of_range))
        else $error("stalled result changed");

    // a waiting input transaction keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(progress))
        else $error("waiting input transaction changed");

endmodule

bind cubic_bezier_evaluator bze_checker #(
    .COORD_BITS(COORD_BITS),
    .PROGRESS_FRAC_BITS(PROGRESS_FRAC_BITS)
) u_bze_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .progress     (progress),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .dir_x        (dir_x),
    .dir_y        (dir_y),
    .out_of_range (out_of_range)
);
